// File: src/vrc_pkg.sv
// Package for the volume render compositor: item types, control structs,
// fixed-point constants and the 2^x mantissa table. No dependencies.
package vrc_pkg;

  localparam int MAX_SAMPLES    = 1024;
  localparam int EXP_TABLE_BITS = 8;
  localparam int TAB_SIZE       = 1 << EXP_TABLE_BITS;
  localparam int CNT_W          = $clog2(MAX_SAMPLES + 1);
  localparam int DIV_STEPS      = 17;  // quotient bits of the sigmoid divide
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [15:0] STEP_RESET  = 16'd256;
  localparam logic [15:0] LIMIT_RESET = 16'd64880;

  // configuration register indexes
  localparam logic CFG_STEP_SIZE     = 1'b0;
  localparam logic CFG_OPACITY_LIMIT = 1'b1;

  typedef struct packed {
    logic signed [15:0] density_raw;
    logic signed [15:0] red_raw;
    logic signed [15:0] green_raw;
    logic signed [15:0] blue_raw;
    logic               sample_valid;
    logic               ray_first;
    logic               ray_last;
  } vrc_in_t;

  typedef struct packed {
    logic [15:0] pixel_red;
    logic [15:0] pixel_green;
    logic [15:0] pixel_blue;
    logic [10:0] samples_used;
    logic        stopped_early;
  } vrc_out_t;

  typedef struct packed {
    logic load;
    logic div_load;
    logic div_step;
    logic commit;
  } vrc_cmd_t;

  typedef struct packed {
    logic out_busy;
  } vrc_stat_t;

  typedef logic [TAB_SIZE-1:0][31:0] pow2_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'd1 << 62;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // tab[k] = 2^(k/TAB_SIZE) in Q.30, from repeated square roots of 2
  function automatic pow2_tab_t build_pow2_tab();
    logic [EXP_TABLE_BITS:0][63:0] roots;
    logic [63:0] acc;
    pow2_tab_t   tab;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= EXP_TABLE_BITS; j++) begin
      roots[j] = isqrt64(roots[j-1] << 30);
    end
    for (int k = 0; k < TAB_SIZE; k++) begin
      acc = 64'd1 << 30;
      for (int i = 0; i < EXP_TABLE_BITS; i++) begin
        if (((k >> i) & 1) != 0) begin
          acc = (acc * roots[EXP_TABLE_BITS - i]) >> 30;
        end
      end
      tab[k] = acc[31:0];
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

// File: src/volume_render_compositor_top.sv
// Volume render compositor: takes one item at a time (accept, front
// multiply stages, divisor load, 17-step sigmoid divide shared timing by
// three lanes, colour multiply, commit); the divide is the longest step.
// Commit waits while a result is held by out_stall; the next item is taken the cycle
// after commit. Synchronous reset clears accumulators, the result valid and
// restores step_size 256, opacity_limit 64880.
module volume_render_compositor_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrc_pkg::vrc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrc_pkg::vrc_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import vrc_pkg::*;

  vrc_cmd_t  cmd;
  vrc_stat_t stat;

  vrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  vrc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting an item");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised outside an item in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.commit)
    else $error("commit while a result is still pending");

endmodule

// File: src/vrc_ctrl.sv
// Controller for the compositor: sequences the datapath for one item.
// Depends on vrc_pkg.
module vrc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrc_pkg::vrc_stat_t stat,
  output vrc_pkg::vrc_cmd_t  cmd
);
  import vrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PIPE, S_DIVLD, S_DIV, S_MUL, S_COMMIT
  } state_t;

  state_t               state;
  logic [DIV_CNT_W-1:0] cnt;

  always_comb begin
    cmd.load     = in_valid && !in_stall;
    cmd.div_load = (state == S_DIVLD);
    cmd.div_step = (state == S_DIV);
    cmd.commit   = (state == S_COMMIT) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      in_stall <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_PIPE;
            cnt      <= '0;
            in_stall <= 1'b1;
          end
        end
        S_PIPE: begin
          // wait here for the front multiplies and the divisor
          if (cnt == DIV_CNT_W'(1)) state <= S_DIVLD;
          cnt <= cnt + 1'b1;
        end
        S_DIVLD: begin
          state <= S_DIV;
          cnt   <= '0;
        end
        S_DIV: begin
          if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) state <= S_MUL;
          cnt <= cnt + 1'b1;
        end
        S_MUL: state <= S_COMMIT;
        S_COMMIT: begin
          if (!stat.out_busy) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/vrc_datapath.sv
// Datapath for the compositor: alpha chain, three sigmoid lanes with
// restoring dividers, accumulators, config registers and result register.
// Depends on vrc_pkg.
module vrc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  vrc_pkg::vrc_cmd_t  cmd,
  output vrc_pkg::vrc_stat_t stat,
  input  vrc_pkg::vrc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vrc_pkg::vrc_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import vrc_pkg::*;

  localparam int TB   = EXP_TABLE_BITS;
  localparam int SH_X = 10 + 16 - TB;

  logic [15:0] step_size;
  logic [15:0] opacity_limit;

  vrc_in_t in_r;

  logic [16:0]      opacity_acc;
  logic [2:0][16:0] col_acc;
  logic [CNT_W-1:0] sample_count;
  logic             ray_done;

  // effective state after an optional ray_first clear
  logic [16:0]      op_eff;
  logic [2:0][16:0] col_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic             done_eff;

  always_comb begin
    op_eff   = in_r.ray_first ? '0 : opacity_acc;
    col_eff  = in_r.ray_first ? '0 : col_acc;
    cnt_eff  = in_r.ray_first ? '0 : sample_count;
    done_eff = in_r.ray_first ? 1'b0 : ray_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size     <= STEP_RESET;
      opacity_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_SIZE:     step_size     <= cfg_data;
        CFG_OPACITY_LIMIT: opacity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
  end

  // ---------------- alpha chain ----------------
  logic signed [33:0] prod_d;
  logic [46:0]        p_b;
  logic signed [7:0]  n_b;
  logic [36:0]        t_c;
  logic               cap_c;
  logic [16:0]        alpha;
  logic [16:0]        weight;

  logic signed [33:0] xq_a;
  logic [TB-1:0]      k_a;
  logic signed [7:0]  n_a;

  always_comb begin
    xq_a = prod_d >>> SH_X;
    k_a  = xq_a[TB-1:0];
    n_a  = 8'(xq_a >>> TB);
  end

  logic [7:0]  sh_c;
  logic [46:0] sv_c;
  logic [19:0] s_c;
  logic        cap_n;

  always_comb begin
    sh_c  = 8'(8'sd30 - n_b);
    sv_c  = '0;
    s_c   = '0;
    cap_n = 1'b0;
    if (p_b == '0) begin
      cap_n = 1'b0;
    end else if (n_b >= 8'sd30) begin
      cap_n = 1'b1;
    end else begin
      sv_c  = (sh_c >= 8'd47) ? '0 : (p_b >> sh_c);
      cap_n = |sv_c[46:20];
      s_c   = sv_c[19:0];
    end
  end

  logic [20:0]        u_d;
  logic signed [21:0] v_d;
  logic signed [21:0] q2_d;
  logic [TB-1:0]      k2_d;
  logic signed [5:0]  n2_d;
  logic [6:0]         sh2_d;
  logic [31:0]        m2_d;
  logic [31:0]        frac_d;

  always_comb begin
    u_d    = t_c[36:16];
    v_d    = -$signed({1'b0, u_d});
    q2_d   = v_d >>> (16 - TB);
    k2_d   = q2_d[TB-1:0];
    n2_d   = 6'(v_d >>> 16);
    sh2_d  = 7'(7'sd14 - 7'(n2_d));
    m2_d   = POW2_TAB[k2_d];
    frac_d = (sh2_d >= 7'd32) ? '0 : (m2_d >> sh2_d);
  end

  always_ff @(posedge clk) begin
    prod_d <= $signed(in_r.density_raw) * $signed(18'(LOG2E_Q16));
    p_b    <= 47'(POW2_TAB[k_a][30:0]) * 47'(step_size);
    n_b    <= n_a;
    t_c    <= 37'(s_c) * 37'(LOG2E_Q16);
    cap_c  <= cap_n;
    alpha  <= cap_c ? ONE_Q16 : 17'(ONE_Q16 - frac_d[16:0]);
    weight <= 17'((34'(ONE_Q16 - op_eff) * 34'(alpha)) >> 16);
  end

  // ---------------- sigmoid lanes ----------------
  logic [2:0][15:0]        c_raw;
  logic signed [2:0][34:0] prod_c;
  logic [2:0][47:0]        den;
  logic [2:0]              sig_zero;
  logic [2:0][48:0]        rem;
  logic [2:0][16:0]        quo;
  logic [2:0][16:0]        col_mul;

  assign c_raw = {in_r.blue_raw, in_r.green_raw, in_r.red_raw};

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [16:0] negc;
      logic signed [34:0] xc;
      logic [TB-1:0]      kc;
      logic signed [7:0]  nc;
      logic [7:0]         shr;
      logic [47:0]        e;
      logic [48:0]        r2;
      logic [16:0]        sig;
      negc = -$signed({c_raw[i][15], c_raw[i]});
      prod_c[i] <= negc * $signed(18'(LOG2E_Q16));
      // a lane select of the packed array is unsigned, so restore the sign
      xc  = $signed(prod_c[i]) >>> SH_X;
      kc  = xc[TB-1:0];
      nc  = 8'(xc >>> TB);
      shr = 8'(-nc);
      if (nc >= 8'sd0) e = 48'(POW2_TAB[kc]) << nc[4:0];
      else if (shr >= 8'd32) e = '0;
      else e = 48'(POW2_TAB[kc]) >> shr;
      sig_zero[i] <= (nc > 8'sd16);
      den[i]      <= (48'd1 << 30) + e;
      // restoring divide of 2^46 by den, one quotient bit per step
      r2 = {rem[i][47:0], 1'b0};
      if (cmd.div_load) begin
        rem[i] <= 49'd1 << 29;
        quo[i] <= '0;
      end else if (cmd.div_step) begin
        if (r2 >= {1'b0, den[i]}) begin
          rem[i] <= r2 - {1'b0, den[i]};
          quo[i] <= {quo[i][15:0], 1'b1};
        end else begin
          rem[i] <= r2;
          quo[i] <= {quo[i][15:0], 1'b0};
        end
      end
      sig = sig_zero[i] ? '0 : quo[i];
      col_mul[i] <= 17'((34'(sig) * 34'(weight)) >> 16);
    end
  end

  // ---------------- commit ----------------
  logic             upd;
  logic [16:0]      op_upd;
  logic [2:0][16:0] col_upd;
  logic [CNT_W-1:0] cnt_upd;
  logic             emit_stop;
  logic             emit_last;

  always_comb begin
    upd     = in_r.sample_valid && !done_eff;
    op_upd  = upd ? 17'(op_eff + weight) : op_eff;
    for (int i = 0; i < 3; i++) begin
      col_upd[i] = upd ? 17'(col_eff[i] + col_mul[i]) : col_eff[i];
    end
    cnt_upd = (upd && cnt_eff < CNT_W'(MAX_SAMPLES)) ? CNT_W'(cnt_eff + 1'b1) : cnt_eff;
    emit_stop = upd && (op_upd > {1'b0, opacity_limit});
    emit_last = !done_eff && !emit_stop && in_r.ray_last;
  end

  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      opacity_acc  <= '0;
      col_acc      <= '0;
      sample_count <= '0;
      ray_done     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (!out_stall) out_valid <= 1'b0;
      if (cmd.commit) begin
        opacity_acc  <= op_upd;
        col_acc      <= col_upd;
        sample_count <= cnt_upd;
        ray_done     <= done_eff || emit_stop || emit_last;
        if (emit_stop || emit_last) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (emit_stop || emit_last)) begin
      out_data.pixel_red     <= col_upd[0][16] ? 16'hFFFF : col_upd[0][15:0];
      out_data.pixel_green   <= col_upd[1][16] ? 16'hFFFF : col_upd[1][15:0];
      out_data.pixel_blue    <= col_upd[2][16] ? 16'hFFFF : col_upd[2][15:0];
      out_data.samples_used  <= 11'(cnt_upd);
      out_data.stopped_early <= emit_stop;
    end
  end

endmodule

// File: dv/tb_volume_render_compositor_top.sv
// Self-checking bench for volume_render_compositor_top: drives ray sample items,
// predicts each pixel result in fixed point and checks the results. Needs vrc_pkg.
`timescale 1ns / 1ps

module tb_volume_render_compositor_top;
  import vrc_pkg::*;

  localparam int          LOG2E   = 94548;
  localparam longint      STEP_CAP = 1048576;
  localparam int          DRAIN   = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  vrc_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  vrc_out_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  volume_render_compositor_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vrc_in_t  sample_q[$];
  vrc_out_t pixel_q[$];
  int       errors;
  int       send_gap;
  int       recv_gap;
  bit       gaps_on;
  int       hold_req;
  int       hold_left;

  // predictor state
  longint unsigned mant_tab[TAB_SIZE];
  longint unsigned step_reg;
  longint unsigned limit_reg;
  longint unsigned opac, acc_r, acc_g, acc_b;
  int unsigned     n_samples;
  bit              ray_closed;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic fill_mant_tab();
    longint unsigned roots[EXP_TABLE_BITS+1];
    longint unsigned acc;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= EXP_TABLE_BITS; j++) roots[j] = int_sqrt(roots[j-1] << 30);
    for (int k = 0; k < TAB_SIZE; k++) begin
      acc = 64'd1 << 30;
      for (int i = 0; i < EXP_TABLE_BITS; i++)
        if ((k >> i) & 1) acc = (acc * roots[EXP_TABLE_BITS-i]) >> 30;
      mant_tab[k] = acc;
    end
  endtask

  // 2^y, y in Q.16: mantissa Q.30 and integer exponent
  function automatic void pow2_split(input longint y, output longint unsigned m,
                                     output longint n);
    longint q;
    q = y >>> (16 - EXP_TABLE_BITS);
    m = mant_tab[q & (TAB_SIZE-1)];
    n = q >>> EXP_TABLE_BITS;
  endfunction

  function automatic longint unsigned alpha_from(longint d);
    longint unsigned m, p, s, t;
    longint n, sh;
    pow2_split((d * LOG2E) >>> 10, m, n);
    p = m * step_reg;
    sh = n - 30;
    if (p == 0) s = 0;
    else if (sh >= 0) s = (sh >= 21 || p >= (STEP_CAP >> sh)) ? STEP_CAP : (p << sh);
    else begin
      s = (-sh >= 64) ? 0 : (p >> (-sh));
      if (s > STEP_CAP) s = STEP_CAP;
    end
    if (s >= STEP_CAP) return 65536;
    t = (s * LOG2E) >> 16;
    pow2_split(-longint'(t), m, n);
    sh = 14 - n;
    return 65536 - (sh >= 64 ? 0 : (m >> sh));
  endfunction

  function automatic longint unsigned sigmoid_q16(longint x);
    longint unsigned m, e;
    longint n;
    pow2_split((-x * LOG2E) >>> 10, m, n);
    if (n > 30) return 0;
    if (n >= 0) e = m << n;
    else e = (-n >= 64) ? 0 : (m >> (-n));
    return (64'd1 << 46) / ((64'd1 << 30) + e);
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic vrc_out_t pixel_now(bit early);
    vrc_out_t r;
    r.pixel_red     = clip16(acc_r);
    r.pixel_green   = clip16(acc_g);
    r.pixel_blue    = clip16(acc_b);
    r.samples_used  = n_samples[10:0];
    r.stopped_early = early;
    return r;
  endfunction

  task automatic composite(vrc_in_t it);
    longint unsigned a, w;
    if (it.ray_first) begin
      opac = 0; acc_r = 0; acc_g = 0; acc_b = 0;
      n_samples = 0;
      ray_closed = 0;
    end
    if (ray_closed) return;
    if (it.sample_valid) begin
      a = alpha_from(longint'($signed(it.density_raw)));
      w = ((65536 - opac) * a) >> 16;
      opac += w;
      acc_r += (sigmoid_q16(longint'($signed(it.red_raw))) * w) >> 16;
      acc_g += (sigmoid_q16(longint'($signed(it.green_raw))) * w) >> 16;
      acc_b += (sigmoid_q16(longint'($signed(it.blue_raw))) * w) >> 16;
      if (n_samples < MAX_SAMPLES) n_samples++;
      if (opac > limit_reg) begin
        pixel_q.push_back(pixel_now(1'b1));
        ray_closed = 1;
        return;
      end
    end
    if (it.ray_last) begin
      pixel_q.push_back(pixel_now(1'b0));
      ray_closed = 1;
    end
  endtask

  // driver: one item at a time from sample_q
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) composite(in_data);
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_data  <= sample_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= gaps_on ? $urandom_range(0, 9) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    vrc_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_data.pixel_red !== want.pixel_red)
            $display("%0t: pixel_red exp %0d got %0d", $time, want.pixel_red, out_data.pixel_red);
          if (out_data.pixel_green !== want.pixel_green)
            $display("%0t: pixel_green exp %0d got %0d", $time, want.pixel_green,
                     out_data.pixel_green);
          if (out_data.pixel_blue !== want.pixel_blue)
            $display("%0t: pixel_blue exp %0d got %0d", $time, want.pixel_blue,
                     out_data.pixel_blue);
          if (out_data.samples_used !== want.samples_used)
            $display("%0t: samples_used exp %0d got %0d", $time, want.samples_used,
                     out_data.samples_used);
          if (out_data.stopped_early !== want.stopped_early)
            $display("%0t: stopped_early exp %0d got %0d", $time, want.stopped_early,
                     out_data.stopped_early);
          if (out_data !== want) errors++;
        end
      end
      if (hold_req > 0 && hold_left == 0) begin
        hold_left <= hold_req;
        hold_req  <= 0;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (out_valid && !out_stall) begin
        recv_gap  <= gaps_on ? $urandom_range(0, 9) : 0;
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic vrc_in_t mk(logic signed [15:0] d, logic signed [15:0] r,
                                 logic signed [15:0] g, logic signed [15:0] b,
                                 bit sv, bit rf, bit rl);
    vrc_in_t it;
    it.density_raw = d; it.red_raw = r; it.green_raw = g; it.blue_raw = b;
    it.sample_valid = sv; it.ray_first = rf; it.ray_last = rl;
    return it;
  endfunction

  function automatic logic [15:0] rnd_density();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 6000));
      default: return 16'($signed($urandom_range(0, 8000)) - 5000);
    endcase
  endfunction

  function automatic logic [15:0] rnd_colour();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16000) - 8000);
  endfunction

  task automatic push_ray(int len, bit marker_end);
    for (int i = 0; i < len; i++)
      sample_q.push_back(mk(rnd_density(), rnd_colour(), rnd_colour(), rnd_colour(), 1'b1,
                            i == 0, !marker_end && i == len - 1));
    if (marker_end || len == 0)
      sample_q.push_back(mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            1'b0, len == 0, 1'b1));
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_STEP_SIZE) step_reg = val;
    else limit_reg = val;
  endtask

  task automatic configure(logic [15:0] stp, logic [15:0] lim);
    write_reg(CFG_STEP_SIZE, stp);
    write_reg(CFG_OPACITY_LIMIT, lim);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin
    fill_mant_tab();
    step_reg = STEP_RESET; limit_reg = LIMIT_RESET;
    opac = 0; acc_r = 0; acc_g = 0; acc_b = 0; n_samples = 0; ray_closed = 0;
    errors = 0; gaps_on = 1; hold_req = 0;
    rst = 1'b1; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_STEP_SIZE; cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed: samples before any ray start, field extremes, a last mark on a sample
    sample_q.push_back(mk(16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh0000, 1'b0, 1'b0, 1'b0));
    sample_q.push_back(mk(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh0000, 1'b1, 1'b0, 1'b0));
    sample_q.push_back(mk(16'sh0400, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b1));
    // empty ray
    sample_q.push_back(mk(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1, 1'b1));
    // opaque sample stops early together with last, then ignored items
    sample_q.push_back(mk(16'sh7FFF, 16'sh0800, -16'sh0800, 16'sh0000, 1'b1, 1'b1, 1'b1));
    sample_q.push_back(mk(16'sh1000, 16'sh0800, 16'sh0800, 16'sh0800, 1'b1, 1'b0, 1'b0));
    sample_q.push_back(mk(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b1));
    // two samples, then an opaque sample that stops early together with the last mark
    sample_q.push_back(mk(16'sh1800, 16'sh2000, 16'sh0000, -16'sh2000, 1'b1, 1'b1, 1'b0));
    sample_q.push_back(mk(16'sh1800, 16'sh2000, 16'sh0000, -16'sh2000, 1'b1, 1'b0, 1'b0));
    sample_q.push_back(mk(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0, 1'b1));
    // ray_first and ray_last on a marker item
    sample_q.push_back(mk(-16'sh1234, 16'sh5555, -16'sh2AAB, 16'sh7FFF, 1'b0, 1'b1, 1'b1));
    push_ray(5, 1'b0);
    push_ray(4, 1'b1);
    drain();

    // highest limit, smallest step: a long ray that stops early only at full opacity
    configure(16'd1, 16'hFFFF);
    gaps_on = 0;
    push_ray(1030, 1'b0);
    drain();
    gaps_on = 1;

    configure(16'hFFFF, 16'd0);
    for (int i = 0; i < 12; i++) push_ray($urandom_range(0, 4), 1'($urandom_range(0, 1)));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       configure(16'd256, 16'd64880);
        1:       configure(16'hFFFF, 16'hFFFF);
        default: configure(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
      endcase
      if (ph == 2) hold_req = 400;
      for (int r = 0; r < 14; r++) begin
        if ($urandom_range(0, 4) != 0) push_ray($urandom_range(0, 16), $urandom_range(0, 2) == 0);
        else for (int k = 0; k < 3; k++)
          sample_q.push_back(mk(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                1'($urandom_range(0, 1)),
                                $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
      end
      if (ph == 3) gaps_on = 0;
      drain();
      gaps_on = 1;
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #1600000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
